// ===== rtl/bad_pkg.sv =====
// Shared types and constants of the block-average decimator.
// Holds the request and result payload structs and the register map.
// No dependencies; the top level, the checker and the testbench refer to it by scoped names.
`default_nettype none

package bad_pkg;

	// Default sizing, handed to the top-level parameters.
	localparam int CHANNELS_DEF    = 8;
	localparam int GROUP_MAX_DEF   = 4096;
	localparam int SAMPLE_BITS_DEF = 32;

	// Fixed field widths of the channels and the register file.
	localparam int CH_W   = 3;
	localparam int DATA_W = 32;
	localparam int GL_W   = 13;
	localparam int ADDR_W = 3;

	localparam logic [GL_W-1:0] GL_RESET = 13'd1;

	// Register index, taken from paddr[2].
	localparam logic REG_GROUP_LENGTH  = 1'b0;
	localparam logic REG_POSITIVE_ONLY = 1'b1;

	typedef struct packed {
		logic [CH_W-1:0]          channel;
		logic signed [DATA_W-1:0] sample;
	} req_t;

	typedef struct packed {
		logic [CH_W-1:0]          out_channel;
		logic signed [DATA_W-1:0] mean;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/bad_div.sv =====
// Iterative signed-by-unsigned divider of the block-average decimator.
// Restoring division, one quotient bit per cycle, quotient truncated toward zero.
// Depends on nothing but its parameters.
`default_nettype none

module bad_div #(
	parameter int SUMW = 44,
	parameter int DENW = 13
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic signed [SUMW-1:0] dividend,
	input  wire logic [DENW-1:0]        divisor,
	output logic                        done,
	output logic [SUMW-1:0]             quotient
);

	localparam int CW = $clog2(SUMW + 1);

	logic            busy_q;
	logic            done_q;
	logic            neg_q;
	logic [CW-1:0]   step_q;
	logic [DENW-1:0] den_q;
	logic [DENW-1:0] rem_q;
	logic [SUMW-1:0] quo_q;

	logic [DENW:0]   trial;
	logic            fits;
	logic [DENW:0]   diff;

	// The dividend magnitude is shifted out of quo_q from the top while the
	// quotient bits are shifted in at the bottom.
	assign trial = {rem_q, quo_q[SUMW-1]};
	assign fits  = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			step_q <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				den_q  <= divisor;
				rem_q  <= '0;
				neg_q  <= dividend[SUMW-1];
				quo_q  <= dividend[SUMW-1] ? ('0 - $unsigned(dividend)) : $unsigned(dividend);
			end else if (busy_q) begin
				rem_q <= fits ? diff[DENW-1:0] : trial[DENW-1:0];
				quo_q <= {quo_q[SUMW-2:0], fits};
				if (step_q == CW'(SUMW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? ('0 - quo_q) : quo_q;

endmodule

`default_nettype wire

// ===== rtl/bad_chan_store.sv =====
// Per-channel accumulator state of the block-average decimator.
// Running sum, sample count and positive-sample count, cleared by reset.
// Depends on nothing but its parameters.
`default_nettype none

module bad_chan_store #(
	parameter int CHANNELS = 8,
	parameter int IDXW     = 3,
	parameter int SUMW     = 44,
	parameter int CNTW     = 13
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [IDXW-1:0]        rd_idx,
	output logic signed [SUMW-1:0]      rd_sum,
	output logic [CNTW-1:0]             rd_cnt,
	output logic [CNTW-1:0]             rd_pos,
	input  wire logic                   wr_en,
	input  wire logic [IDXW-1:0]        wr_idx,
	input  wire logic signed [SUMW-1:0] wr_sum,
	input  wire logic [CNTW-1:0]        wr_cnt,
	input  wire logic [CNTW-1:0]        wr_pos
);

	logic signed [SUMW-1:0] sum_q [CHANNELS];
	logic [CNTW-1:0]        cnt_q [CHANNELS];
	logic [CNTW-1:0]        pos_q [CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sum_q[i] <= '0;
				cnt_q[i] <= '0;
				pos_q[i] <= '0;
			end
		end else if (wr_en) begin
			sum_q[wr_idx] <= wr_sum;
			cnt_q[wr_idx] <= wr_cnt;
			pos_q[wr_idx] <= wr_pos;
		end
	end

	assign rd_sum = sum_q[rd_idx];
	assign rd_cnt = cnt_q[rd_idx];
	assign rd_pos = pos_q[rd_idx];

endmodule

`default_nettype wire

// ===== rtl/block_average_decimator.sv =====
// Block-average decimator: one running average per channel over fixed-size groups.
// Instantiates bad_chan_store and bad_div; uses the types of bad_pkg.
//
// Requests (req_valid/req_ready/req) carry a channel and a signed Q16.16
// sample. The block takes one request at a time: req_ready is high only while
// the sequencer is idle. A request that does not close its channel's group
// is accepted and then passes through the accumulate cycle, in which the
// channel state is read, updated and written back. A request that closes a
// group starts the shared one-bit-per-cycle divider, which runs SUMW =
// SAMPLE_BITS + clog2(GROUP_MAX) steps; the result (rsp_valid/rsp_ready/rsp)
// then passes from S_DIV through S_PUT into the output register, and the
// next request can be taken in the same cycle in which the result appears.
// In positive-only mode a group without a positive sample skips the divider;
// its zero result goes from S_ACC straight to S_PUT.
// Results sit in an output register; a stalled receiver holds the next
// group-closing request in S_PUT, which keeps req_ready low until it frees.
// Reset clears every channel's sum and counts, group_length to 1 and
// positive_only to 0. Registers are written over the APB port: group_length
// at 0x0, positive_only at 0x4; pready is always high.
`default_nettype none

module block_average_decimator #(
	parameter int CHANNELS    = bad_pkg::CHANNELS_DEF,
	parameter int GROUP_MAX   = bad_pkg::GROUP_MAX_DEF,
	parameter int SAMPLE_BITS = bad_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_ready,
	input  wire bad_pkg::req_t                req,
	output logic                              rsp_valid,
	input  wire logic                         rsp_ready,
	output bad_pkg::rsp_t                     rsp,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [bad_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [bad_pkg::DATA_W-1:0]   pwdata,
	output logic [bad_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);

	localparam int IDXW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNTW = $clog2(GROUP_MAX + 1);
	localparam int SUMW = SAMPLE_BITS + $clog2(GROUP_MAX);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ACC,
		S_DIV,
		S_PUT
	} state_t;

	// Configuration registers.
	logic [bad_pkg::GL_W-1:0] gl_q;
	logic                     pos_only_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gl_q       <= bad_pkg::GL_RESET;
			pos_only_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				bad_pkg::REG_GROUP_LENGTH:  gl_q       <= pwdata[bad_pkg::GL_W-1:0];
				bad_pkg::REG_POSITIVE_ONLY: pos_only_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			bad_pkg::REG_GROUP_LENGTH:  prdata = bad_pkg::DATA_W'(gl_q);
			bad_pkg::REG_POSITIVE_ONLY: prdata = bad_pkg::DATA_W'(pos_only_q);
			default:                    prdata = '0;
		endcase
	end

	// Effective group length: zero acts as one, large values saturate.
	logic [CNTW-1:0] len_eff;

	always_comb begin
		if (gl_q == '0)
			len_eff = CNTW'(1);
		else if (32'(gl_q) > GROUP_MAX)
			len_eff = CNTW'(GROUP_MAX);
		else
			len_eff = CNTW'(gl_q);
	end

	// Request decode: the low SAMPLE_BITS of the field form the signed code.
	logic [SAMPLE_BITS-1:0] s_lo;
	logic signed [SUMW-1:0] s_ext;
	logic                   s_pos;
	logic                   ch_ok;

	assign s_lo  = SAMPLE_BITS'($unsigned(req.sample));
	assign s_ext = SUMW'($signed(s_lo));
	assign s_pos = !s_lo[SAMPLE_BITS-1] && (s_lo != '0);
	assign ch_ok = (32'(req.channel) < CHANNELS);

	state_t                     state_q;
	logic [bad_pkg::CH_W-1:0]   ch_q;
	logic signed [SUMW-1:0]     smp_q;
	logic                       pos_q;
	logic                       ok_q;
	logic [bad_pkg::DATA_W-1:0] mean_q;
	logic                       rsp_valid_q;
	bad_pkg::rsp_t              rsp_q;

	// Channel state access during the accumulate cycle.
	logic signed [SUMW-1:0] rd_sum;
	logic [CNTW-1:0]        rd_cnt;
	logic [CNTW-1:0]        rd_pos;
	logic signed [SUMW-1:0] new_sum;
	logic [CNTW-1:0]        new_cnt;
	logic [CNTW-1:0]        new_pos;
	logic                   closing;
	logic                   acc_go;
	logic                   no_pos;
	logic                   div_start;
	logic [CNTW-1:0]        div_den;
	logic                   div_done;
	logic [SUMW-1:0]        div_quo;
	logic [IDXW-1:0]        idx;

	assign idx     = IDXW'(ch_q);
	assign new_sum = rd_sum + ((!pos_only_q || pos_q) ? smp_q : '0);
	assign new_cnt = rd_cnt + 1'b1;
	assign new_pos = rd_pos + CNTW'(pos_q);
	assign closing = (new_cnt >= len_eff);
	assign acc_go  = (state_q == S_ACC) && ok_q;
	assign no_pos  = pos_only_q && (new_pos == '0);

	assign div_start = acc_go && closing && !no_pos;
	assign div_den   = pos_only_q ? new_pos : new_cnt;

	bad_chan_store #(
		.CHANNELS (CHANNELS),
		.IDXW     (IDXW),
		.SUMW     (SUMW),
		.CNTW     (CNTW)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (idx),
		.rd_sum (rd_sum),
		.rd_cnt (rd_cnt),
		.rd_pos (rd_pos),
		.wr_en  (acc_go),
		.wr_idx (idx),
		.wr_sum (closing ? '0 : new_sum),
		.wr_cnt (closing ? '0 : new_cnt),
		.wr_pos (closing ? '0 : new_pos)
	);

	bad_div #(
		.SUMW (SUMW),
		.DENW (CNTW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (new_sum),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	logic out_load;

	assign out_load  = (state_q == S_PUT) && (!rsp_valid_q || rsp_ready);
	assign req_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= '0;
			smp_q       <= '0;
			pos_q       <= 1'b0;
			ok_q        <= 1'b0;
			mean_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready && !out_load)
				rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						ch_q    <= req.channel;
						smp_q   <= s_ext;
						pos_q   <= s_pos;
						ok_q    <= ch_ok;
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (!ok_q || !closing) begin
						state_q <= S_IDLE;
					end else if (no_pos) begin
						mean_q  <= '0;
						state_q <= S_PUT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						mean_q  <= bad_pkg::DATA_W'(div_quo[SAMPLE_BITS-1:0]);
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (out_load) begin
						rsp_valid_q       <= 1'b1;
						rsp_q.out_channel <= ch_q;
						rsp_q.mean        <= mean_q;
						state_q           <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// An accepted request always goes through the accumulate cycle.
	a_accept_acc: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> state_q == S_ACC)
		else $error("accepted request did not enter the accumulate cycle");

	// The divider only finishes while the sequencer waits for it.
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the divide wait");

	// A stored positive count never exceeds the stored sample count.
	a_pos_le_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pos <= rd_cnt)
		else $error("positive count above sample count");

	// A pending result with a free output register is loaded into it next cycle.
	a_put_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PUT && !rsp_valid_q |=> rsp_valid_q)
		else $error("result not loaded into a free output register");

endmodule

`default_nettype wire

// ===== verif/bad_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the block-average decimator: mirrors the registers from the APB port,
// predicts each channel's group mean from accepted requests and checks every result.
// Depends on bad_pkg for the payload types and the register indexes.

module bad_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  logic                         req_ready,
	input  bad_pkg::req_t                req,
	input  logic                         rsp_valid,
	input  logic                         rsp_ready,
	input  bad_pkg::rsp_t                rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bad_pkg::ADDR_W-1:0]   paddr,
	input  logic [bad_pkg::DATA_W-1:0]   pwdata,
	input  logic [bad_pkg::DATA_W-1:0]   prdata,
	input  logic                         pready,
	output int                           errors,
	output int                           outstanding
);

	localparam int NCH  = bad_pkg::CHANNELS_DEF;
	localparam int GMAX = bad_pkg::GROUP_MAX_DEF;

	logic [bad_pkg::GL_W-1:0] group_len;
	logic                     pos_only;
	longint                   group_sum [NCH];
	int unsigned              group_cnt [NCH];
	int unsigned              pos_cnt   [NCH];
	bad_pkg::rsp_t            expected_means [$];

	// Folds one sample into its channel and queues the mean when the group closes.
	task automatic accumulate_sample(input bad_pkg::req_t r);
		int unsigned   ch;
		longint        s;
		int unsigned   len;
		longint        q;
		bad_pkg::rsp_t res;
		ch = r.channel;
		s = longint'($signed(r.sample));
		if (ch >= NCH)
			return;
		len = group_len;
		if (len == 0)
			len = 1;
		if (len > GMAX)
			len = GMAX;
		if (!pos_only || s > 0)
			group_sum[ch] = group_sum[ch] + s;
		if (s > 0)
			pos_cnt[ch]++;
		group_cnt[ch]++;
		if (group_cnt[ch] < len)
			return;
		if (!pos_only)
			q = group_sum[ch] / longint'(group_cnt[ch]);
		else if (pos_cnt[ch] == 0)
			q = 0;
		else
			q = group_sum[ch] / longint'(pos_cnt[ch]);
		res.out_channel = r.channel;
		res.mean = q[31:0];
		expected_means = {expected_means, res};
		group_sum[ch] = 0;
		group_cnt[ch] = 0;
		pos_cnt[ch] = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		bad_pkg::rsp_t            want;
		logic [bad_pkg::DATA_W-1:0] reg_value;
		if (!arst_n) begin
			group_len = bad_pkg::GL_RESET;
			pos_only = 1'b0;
			for (int i = 0; i < NCH; i++) begin
				group_sum[i] = 0;
				group_cnt[i] = 0;
				pos_cnt[i] = 0;
			end
			expected_means.delete();
			errors = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_means.size() == 0) begin
					$error("unexpected result: out_channel %0d mean %0d",
						rsp.out_channel, $signed(rsp.mean));
					errors++;
				end else begin
					want = expected_means.pop_front();
					if (rsp.out_channel !== want.out_channel) begin
						$error("out_channel: expected %0d, got %0d",
							want.out_channel, rsp.out_channel);
						errors++;
					end
					if (rsp.mean !== want.mean) begin
						$error("mean: expected %0d, got %0d",
							$signed(want.mean), $signed(rsp.mean));
						errors++;
					end
				end
			end
			if (req_valid && req_ready)
				accumulate_sample(req);
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == bad_pkg::REG_GROUP_LENGTH)
						group_len = pwdata[bad_pkg::GL_W-1:0];
					else
						pos_only = pwdata[0];
				end else begin
					if (paddr[2] == bad_pkg::REG_GROUP_LENGTH)
						reg_value = {{(bad_pkg::DATA_W-bad_pkg::GL_W){1'b0}}, group_len};
					else
						reg_value = {{(bad_pkg::DATA_W-1){1'b0}}, pos_only};
					if (prdata !== reg_value) begin
						$error("prdata: expected %0d, got %0d", reg_value, prdata);
						errors++;
					end
				end
			end
		end
		outstanding = expected_means.size();
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the block-average decimator testbench: clock, reset, request and
// register stimulus with random gaps and result stalls, and the verdict.
// Depends on bad_pkg, the block itself and the bad_checker scoreboard.

module tb_top;

	localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

	logic                         clk;
	logic                         arst_n;
	logic                         req_valid;
	logic                         req_ready;
	bad_pkg::req_t                req;
	logic                         rsp_valid;
	logic                         rsp_ready;
	bad_pkg::rsp_t                rsp;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [bad_pkg::ADDR_W-1:0]   paddr;
	logic [bad_pkg::DATA_W-1:0]   pwdata;
	logic [bad_pkg::DATA_W-1:0]   prdata;
	logic                         pready;
	int                           errors;
	int                           outstanding;
	logic                         gaps_on;

	block_average_decimator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	bad_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#4_000_000;
		$display("block_average_decimator verification failed");
		$finish;
	end

	// Result side stalls on its own, independent of the request side.
	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ready <= !gaps_on || ($urandom_range(99) >= 14);
		end
	end

	task automatic send_sample(input logic [2:0] ch, input logic signed [31:0] s);
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < 14) begin
			req_valid <= 1'b0;
			req <= '{channel: 3'($urandom), sample: $urandom};
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= '{channel: ch, sample: s};
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic apb_access(input logic idx, input logic wr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Waits for every pending mean, then lets any request that closed no group
	// finish its accumulate cycle, before the registers are touched.
	task automatic drain_block();
		@(negedge clk);
		req_valid <= 1'b0;
		wait (outstanding == 0);
		repeat (64) @(negedge clk);
	endtask

	task automatic set_mode(input logic [12:0] len, input logic pos);
		drain_block();
		apb_access(bad_pkg::REG_GROUP_LENGTH, 1'b1, ($urandom & 32'hFFFF_E000) | {19'd0, len});
		apb_access(bad_pkg::REG_POSITIVE_ONLY, 1'b1, {$urandom} & 32'hFFFF_FFFE | {31'd0, pos});
		apb_access(bad_pkg::REG_GROUP_LENGTH, 1'b0, 32'd0);
		apb_access(bad_pkg::REG_POSITIVE_ONLY, 1'b0, 32'd0);
	endtask

	function automatic logic signed [31:0] pick_sample();
		case ($urandom_range(7))
			0: return S_MAX;
			1: return S_MIN;
			2: return 32'sd0;
			3: return $urandom_range(1) ? 32'sd1 : -32'sd1;
			4, 5: return int'($urandom_range(2000)) - 1000;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(input logic [12:0] len, input logic pos, input int count);
		set_mode(len, pos);
		repeat (count)
			send_sample(3'($urandom_range(7)), pick_sample());
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		gaps_on = 1'b1;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Reset values read back, then one mean per sample.
		apb_access(bad_pkg::REG_GROUP_LENGTH, 1'b0, 32'd0);
		apb_access(bad_pkg::REG_POSITIVE_ONLY, 1'b0, 32'd0);
		send_sample(3'd0, S_MAX);
		send_sample(3'd7, S_MIN);
		send_sample(3'd3, 32'sd0);
		send_sample(3'd1, -32'sd1);
		send_sample(3'd2, 32'sd1);
		send_sample(3'd4, 32'sh0001_0000);

		// A group length of zero behaves as one.
		set_mode(13'd0, 1'b0);
		send_sample(3'd5, S_MIN);
		send_sample(3'd6, 32'sh1234_5678);

		// Pairs: extremes and truncation of negative quotients toward zero.
		set_mode(13'd2, 1'b0);
		send_sample(3'd6, S_MAX);
		send_sample(3'd6, S_MAX);
		send_sample(3'd0, S_MIN);
		send_sample(3'd0, S_MIN);
		send_sample(3'd1, -32'sd1);
		send_sample(3'd1, 32'sd0);
		send_sample(3'd2, -32'sd3);
		send_sample(3'd2, 32'sd0);

		// Positive-only mode: a group with no positive sample gives zero.
		set_mode(13'd3, 1'b1);
		send_sample(3'd4, 32'sd0);
		send_sample(3'd4, -32'sd1);
		send_sample(3'd4, S_MIN);
		send_sample(3'd3, 32'sd5);
		send_sample(3'd3, -32'sd7);
		send_sample(3'd3, 32'sd2);

		// Length lowered below a partial count: the next sample closes the group.
		set_mode(13'd4, 1'b0);
		send_sample(3'd5, 32'sd10);
		send_sample(3'd5, 32'sd20);
		set_mode(13'd2, 1'b0);
		send_sample(3'd5, -32'sd100);

		// A long group of extremes carries the running sum far past 32 bits.
		// A length above the maximum saturates and closes nothing early; the
		// group is then closed by lowering the length.
		set_mode(13'd128, 1'b0);
		repeat (128) send_sample(3'd5, S_MAX);
		set_mode(13'd8191, 1'b0);
		repeat (60) send_sample(3'd2, S_MIN);
		set_mode(13'd2, 1'b0);
		send_sample(3'd2, S_MIN);

		// Random phases; partial groups carry over across mode and length changes.
		random_phase(13'd3, 1'b0, 70);
		random_phase(13'd1, 1'b1, 40);
		random_phase(13'd7, 1'b1, 70);
		gaps_on = 1'b0;
		random_phase(13'd2, 1'b0, 60);
		gaps_on = 1'b1;
		random_phase(13'd16, 1'b0, 80);
		random_phase(13'd5, 1'b1, 70);
		random_phase(13'd4, 1'b0, 80);
		random_phase(13'd9, 1'b1, 70);

		drain_block();
		if (errors == 0)
			$display("block_average_decimator verification clean");
		else
			$display("block_average_decimator verification failed");
		$finish;
	end

endmodule

// ===== block_average_decimator.f =====
rtl/bad_pkg.sv
rtl/bad_div.sv
rtl/bad_chan_store.sv
rtl/block_average_decimator.sv
verif/bad_checker.sv
verif/tb_top.sv
